### hdl/itoa_pkg.sv
package itoa_pkg;

  // ascii codes used by the character formatter
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;
  localparam logic [4:0] RADIX_DEC = 5'd10;

  // dividend bits retired by the divider per cycle
  localparam int STEP_BITS = 8;

  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  radix;
  } in_req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic [5:0] total_length;
  } out_res_t;

  // request to the shared divider
  typedef struct packed {
    logic       start;
    logic       pow2;
    logic [2:0] shift;
  } div_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS,
    ST_TERM
  } state_t;

  function automatic logic [7:0] digit_to_char(input logic [3:0] d);
    logic [7:0] ch;
    if (d > 4'd9) begin
      ch = CHAR_A + 8'(d) - 8'd10;
    end else begin
      ch = CHAR_ZERO + 8'(d);
    end
    return ch;
  endfunction

endpackage

### hdl/itoa_ram.sv
module itoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/itoa_div.sv
module itoa_div #(
  parameter int DATA_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  itoa_pkg::div_ctrl_t     ctrl,
  input  logic [DATA_BITS-1:0]    dividend,
  input  logic [4:0]              radix,
  output logic                    done,
  output logic [DATA_BITS-1:0]    quotient,
  output logic [3:0]              remainder
);

  import itoa_pkg::*;

  localparam int STEPS = (DATA_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W = STEPS * STEP_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [PAD_W-1:0] quo;
  logic [4:0]       rem;
  logic [PAD_W-1:0] quo_next;
  logic [4:0]       rem_next;
  logic [3:0]       mask;

  // restoring division, STEP_BITS quotient bits per cycle
  always_comb begin
    logic [PAD_W-1:0] q;
    logic [4:0]       r;
    logic [4:0]       t;
    q = quo;
    r = rem;
    for (int k = 0; k < STEP_BITS; k++) begin
      t = {r[3:0], q[PAD_W-1]};
      q = {q[PAD_W-2:0], 1'b0};
      if (t >= radix) begin
        t = t - radix;
        q[0] = 1'b1;
      end
      r = t;
    end
    quo_next = q;
    rem_next = r;
  end

  assign mask = 4'((5'd1 << ctrl.shift) - 5'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        if (ctrl.pow2) begin
          // power-of-two radix: shift and mask, with no division steps
          quo  <= PAD_W'(dividend >> ctrl.shift);
          rem  <= {1'b0, dividend[3:0] & mask};
          done <= 1'b1;
        end else begin
          quo  <= PAD_W'(dividend);
          rem  <= '0;
          cnt  <= CNT_W'(STEPS);
          busy <= 1'b1;
        end
      end else if (busy) begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo[DATA_BITS-1:0];
  assign remainder = rem[3:0];

endmodule

### hdl/integer_to_radix_ascii_top.sv
// Integer to ASCII text in radix 2 to 16. Each request carries a word and a radix;
// the block answers with one result per character, most significant digit first,
// lower-case letters for digit values 10 to 15, and a NUL terminator flagged by
// last that also carries the string length including the terminator. Radix 10
// reads the word as signed and prefixes '-' on negative values; every other radix
// reads it as unsigned. A radix below 2 acts as 2, above 16 as 16. Only the low
// DATA_BITS bits of value are used. src_stall is high from acceptance until the
// terminator has been placed in the output register, so one word is in flight at
// a time. Digits come from one shared divider that retires 8 dividend bits per
// cycle, or shifts and masks without division steps when the radix is a power of
// two. Digits land in a small RAM, least significant first, and are read back in
// reverse through its registered read port.
module integer_to_radix_ascii_top #(
  parameter int DATA_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  itoa_pkg::in_req_t  src_item,
  output logic               dst_valid,
  input  logic               dst_stall,
  output itoa_pkg::out_res_t dst_item
);

  import itoa_pkg::*;

  localparam int CNT_W = $clog2(DATA_BITS + 1);
  localparam int AW    = $clog2(DATA_BITS);

  // sequencer state
  state_t           state, state_next;
  logic [4:0]       radix_r, radix_next;
  logic             negative, negative_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             fetch_valid, fetch_next;

  // request decode
  logic [4:0]           radix_in;
  logic [4:0]           radix_sel;
  logic [DATA_BITS-1:0] word_in;
  logic                 neg_in;
  logic [DATA_BITS-1:0] mag_in;
  logic                 pow2_sel;
  logic [2:0]           shift_sel;

  // divider hookup
  div_ctrl_t            div_ctrl;
  logic [DATA_BITS-1:0] dividend;
  logic                 div_done;
  logic [DATA_BITS-1:0] div_quotient;
  logic [3:0]           div_remainder;

  // digit store hookup
  logic       wr_en;
  logic       rd_en;
  logic [3:0] rd_data;

  // output register load
  logic     can_load;
  logic     load;
  out_res_t load_item;
  logic [CNT_W:0] len_full;

  // clamp the radix into 2..16
  always_comb begin
    if (src_item.radix < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (src_item.radix > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = src_item.radix;
    end
  end

  // sign only matters in decimal; the magnitude of the most negative word fits unsigned
  assign word_in = DATA_BITS'(src_item.value);
  assign neg_in  = (radix_in == RADIX_DEC) && word_in[DATA_BITS-1];
  assign mag_in  = neg_in ? (~word_in + DATA_BITS'(1)) : word_in;

  // the divider is started from idle with the fresh radix, later with the held one
  assign radix_sel = (state == ST_IDLE) ? radix_in : radix_r;

  always_comb begin
    unique case (radix_sel)
      5'd2:    begin pow2_sel = 1'b1; shift_sel = 3'd1; end
      5'd4:    begin pow2_sel = 1'b1; shift_sel = 3'd2; end
      5'd8:    begin pow2_sel = 1'b1; shift_sel = 3'd3; end
      5'd16:   begin pow2_sel = 1'b1; shift_sel = 3'd4; end
      default: begin pow2_sel = 1'b0; shift_sel = 3'd0; end
    endcase
  end

  // output register frees up when empty or being taken this cycle
  assign can_load = !dst_valid || !dst_stall;

  // length including the terminator, truncated to the field width
  assign len_full = (CNT_W+1)'(count) + (CNT_W+1)'(negative) + (CNT_W+1)'(1);

  always_comb begin
    state_next    = state;
    radix_next    = radix_r;
    negative_next = negative;
    count_next    = count;
    idx_next      = idx;
    fetch_next    = fetch_valid;
    div_ctrl      = '0;
    dividend      = div_quotient;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    load          = 1'b0;
    load_item     = '0;
    src_stall     = (state != ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (src_valid) begin
          // first division goes out in the accept cycle
          div_ctrl.start = 1'b1;
          div_ctrl.pow2  = pow2_sel;
          div_ctrl.shift = shift_sel;
          dividend       = mag_in;
          radix_next     = radix_in;
          negative_next  = neg_in;
          count_next     = '0;
          state_next     = ST_CONV;
        end
      end

      ST_CONV: begin
        if (div_done) begin
          // store the digit; a zero word still yields one digit
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
          if (div_quotient != '0) begin
            div_ctrl.start = 1'b1;
            div_ctrl.pow2  = pow2_sel;
            div_ctrl.shift = shift_sel;
          end else begin
            idx_next   = count + CNT_W'(1);
            fetch_next = 1'b0;
            state_next = negative ? ST_SIGN : ST_DIGITS;
          end
        end
      end

      ST_SIGN: begin
        if (can_load) begin
          load                = 1'b1;
          load_item.character = CHAR_MINUS;
          state_next          = ST_DIGITS;
        end
      end

      ST_DIGITS: begin
        // read back most significant first; rd_data holds one prefetched digit
        if (fetch_valid && can_load) begin
          load                = 1'b1;
          load_item.character = digit_to_char(rd_data);
        end
        if ((idx != '0) && (!fetch_valid || load)) begin
          rd_en      = 1'b1;
          idx_next   = idx - CNT_W'(1);
          fetch_next = 1'b1;
        end else if (load) begin
          fetch_next = 1'b0;
        end
        if ((idx == '0) && !fetch_valid) begin
          state_next = ST_TERM;
        end
      end

      ST_TERM: begin
        if (can_load) begin
          load                   = 1'b1;
          load_item.character    = CHAR_NUL;
          load_item.last         = 1'b1;
          load_item.total_length = 6'(len_full);
          state_next             = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_r     <= RADIX_MIN;
      negative    <= 1'b0;
      count       <= '0;
      idx         <= '0;
      fetch_valid <= 1'b0;
    end else begin
      radix_r     <= radix_next;
      negative    <= negative_next;
      count       <= count_next;
      idx         <= idx_next;
      fetch_valid <= fetch_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (load) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dst_item <= load_item;
    end
  end

  // shared digit divider
  itoa_div #(
    .DATA_BITS (DATA_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (dividend),
    .radix     (radix_r),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // digit store, least significant digit at address 0
  itoa_ram #(
    .WIDTH (4),
    .DEPTH (DATA_BITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (div_remainder),
    .rd_en   (rd_en),
    .rd_addr (idx_next[AW-1:0]),
    .rd_data (rd_data)
  );

  // an accepted request keeps the block busy on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    src_valid && !src_stall |=> src_stall)
    else $error("block not busy after accepting a request");

  // only the terminator carries a length
  assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_item.last |-> dst_item.total_length == 6'd0)
    else $error("length on a non-terminator result");

  // digit count never passes the word width
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DATA_BITS))
    else $error("digit count out of range");

  // a digit is only stored while converting
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == ST_CONV)
    else $error("digit write outside conversion");

endmodule
